// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock, disabled while the named reset is high.
`define MWM_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the usual clock and reset names of this project.
`define MWM_ASSERT(lbl, prop, msg) \
   `MWM_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== rtl/core/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze wall map package
// Types, codes and helper functions shared by the wall map store modules.
// ----------------------------------------------------------------------------
package mwm_pkg;

   // Default grid size.
   localparam int GRID_WIDTH_DEF  = 8;
   localparam int GRID_HEIGHT_DEF = 8;

   // Cells-left counter.
   localparam int         CELLS_W     = 9;
   localparam logic [8:0] CELLS_RESET = 9'd64;

   // Operation codes.
   localparam logic [1:0] OP_WALL     = 2'd0;
   localparam logic [1:0] OP_OBSTACLE = 2'd1;
   localparam logic [1:0] OP_ENTER    = 2'd2;

   // Direction codes.
   localparam logic [1:0] DIR_SOUTH = 2'd0;
   localparam logic [1:0] DIR_WEST  = 2'd1;
   localparam logic [1:0] DIR_NORTH = 2'd2;
   localparam logic [1:0] DIR_EAST  = 2'd3;

   // Wall marks, two-bit two's complement.
   localparam logic [1:0] WALL_UNKNOWN = 2'b11;
   localparam logic [1:0] WALL_OPEN    = 2'b00;
   localparam logic [1:0] WALL_CLOSED  = 2'b01;

   // Cell status codes.
   localparam logic [1:0] STAT_UNVISITED = 2'd0;
   localparam logic [1:0] STAT_MAPPED    = 2'd1;
   localparam logic [1:0] STAT_OBSTACLE  = 2'd2;

   // One table entry: four walls indexed by direction code, and a status.
   typedef struct packed {
      logic [3:0][1:0] wall;
      logic [1:0]      status;
   } cell_entry_type;

   // One accepted request.
   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] cell_x;
      logic [2:0] cell_y;
      logic [1:0] heading;
      logic       wall_closed;
      logic [1:0] turns;
   } req_type;

   // Write strobes and result fields from the update logic.
   typedef struct packed {
      logic       wr_cur;
      logic       wr_ahead;
      logic [1:0] ahead_status;
      logic [1:0] asked_wall;
      logic [1:0] cell_status;
   } upd_ctl_type;

   // Value of an entry that has not been written since reset.
   function automatic cell_entry_type reset_entry(input logic [3:0] x, input logic [3:0] y,
                                                  input int width, input int height);
      cell_entry_type e;
      e.wall[DIR_SOUTH] = (int'(y) == height - 1) ? WALL_CLOSED : WALL_UNKNOWN;
      e.wall[DIR_WEST]  = (x == 4'd0) ? WALL_CLOSED : WALL_UNKNOWN;
      e.wall[DIR_NORTH] = (y == 4'd0) ? WALL_CLOSED : WALL_UNKNOWN;
      e.wall[DIR_EAST]  = (int'(x) == width - 1) ? WALL_CLOSED : WALL_UNKNOWN;
      e.status          = STAT_UNVISITED;
      return e;
   endfunction

   // True when an unvisited cell has all four walls known.
   function automatic logic settles(input cell_entry_type e);
      return (e.status == STAT_UNVISITED) &&
             (e.wall[0] != WALL_UNKNOWN) && (e.wall[1] != WALL_UNKNOWN) &&
             (e.wall[2] != WALL_UNKNOWN) && (e.wall[3] != WALL_UNKNOWN);
   endfunction

endpackage

// ===== rtl/core/mwm_table.sv =====
// ----------------------------------------------------------------------------
// Cell table memory
// Synchronous memory of cell entries with one write and one registered read
// port. Per-entry valid bits mark entries written since reset.
// ----------------------------------------------------------------------------
module mwm_table
   import mwm_pkg::*;
#(
   parameter int DEPTH  = GRID_WIDTH_DEF * GRID_HEIGHT_DEF,
   parameter int ADDR_W = $clog2(GRID_WIDTH_DEF * GRID_HEIGHT_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cell_entry_type    wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_entry_type    rd_data,
   output logic              rd_valid
);

   cell_entry_type mem [DEPTH];
   cell_entry_type rd_data_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             rd_valid_ff;
   logic             rd_valid_in;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // A written entry becomes valid; addresses beyond the table read as unwritten.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = (int'(rd_addr) < DEPTH) ? valid_ff[rd_addr] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== rtl/core/mwm_update.sv =====
// ----------------------------------------------------------------------------
// Cell update logic
// Applies one operation to the current and ahead entries, settles cells whose
// walls are all known, and forms the result fields and the new count.
// ----------------------------------------------------------------------------
module mwm_update
   import mwm_pkg::*;
(
   input  req_type              req,
   input  logic                 cur_in,
   input  logic                 ahead_in,
   input  cell_entry_type       cur_entry,
   input  cell_entry_type       ahead_entry,
   input  logic [CELLS_W-1:0]   count_cur,
   output cell_entry_type       cur_new,
   output cell_entry_type       ahead_new,
   output upd_ctl_type          ctl,
   output logic [CELLS_W-1:0]   count_new
);

   logic [1:0] reading;
   logic [1:0] opp_dir;
   logic [1:0] asked_dir;
   logic [1:0] dec;

   always_comb begin
      reading   = {1'b0, req.wall_closed};
      opp_dir   = req.heading + 2'd2;
      asked_dir = req.heading + req.turns;
      cur_new   = cur_entry;
      ahead_new = ahead_entry;
      dec       = 2'd0;
      ctl       = '0;

      // Table changes only when the current cell lies in the grid.
      if (cur_in) begin
         case (req.operation)
            OP_WALL: begin
               cur_new.wall[req.heading] = reading;
               ctl.wr_cur = 1'b1;
               // The neighbour is settled before the current cell.
               if (ahead_in) begin
                  ahead_new.wall[opp_dir] = reading;
                  ctl.wr_ahead = 1'b1;
                  if (settles(ahead_new)) begin
                     ahead_new.status = STAT_MAPPED;
                     dec = dec + 2'd1;
                  end
               end
               if (settles(cur_new)) begin
                  cur_new.status = STAT_MAPPED;
                  dec = dec + 2'd1;
               end
            end
            OP_OBSTACLE: begin
               if (ahead_in) begin
                  ahead_new.status = STAT_OBSTACLE;
                  ctl.wr_ahead = 1'b1;
                  dec = 2'd1;
               end
            end
            OP_ENTER: begin
               cur_new.status = STAT_MAPPED;
               ctl.wr_cur = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Result fields; a cell outside the grid reports as mapped.
      if (cur_in) begin
         ctl.ahead_status = ahead_in ? ahead_new.status : STAT_MAPPED;
         ctl.asked_wall   = cur_new.wall[asked_dir];
         ctl.cell_status  = cur_new.status;
      end else begin
         ctl.ahead_status = STAT_MAPPED;
         ctl.asked_wall   = WALL_UNKNOWN;
         ctl.cell_status  = STAT_MAPPED;
      end

      // Successive saturating decrements equal one clamped subtraction.
      count_new = (count_cur > {7'b0, dec}) ? (count_cur - {7'b0, dec}) : '0;
   end

endmodule

// ===== rtl/core/maze_wall_map_store.sv =====
// Sequence: the current entry is read as a request is taken, the entry ahead in
//   S_RD_AHD; S_MODIFY writes the ahead entry back, S_WR_CUR the current one and
//   the response, which S_HOLD loads instead once a stalled output is free.
// New requests wait for S_IDLE; the memory is read twice, written at most twice.
// Reset: clears the entry valid bits, so the table reads as border walls closed,
//   other walls unknown and all cells unvisited at once; the count loads 64.
// ----------------------------------------------------------------------------
// Maze wall map store
// Grid map of maze walls and cell status, kept in a synchronous memory and
// updated by read-modify-write, with a saturating count of cells to be mapped.
// ----------------------------------------------------------------------------
module maze_wall_map_store
   import mwm_pkg::*;
#(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // Configuration write channel.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CELLS_W-1:0]  csr_initial_cells,
   // Request channel.
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [2:0]          req_cell_x,
   input  logic [2:0]          req_cell_y,
   input  logic [1:0]          req_heading,
   input  logic                req_wall_closed,
   input  logic [1:0]          req_turns,
   // Response channel.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_ahead_status,
   output logic signed [1:0]   rsp_asked_wall,
   output logic [1:0]          rsp_cell_status,
   output logic [CELLS_W-1:0]  rsp_cells_left
);

   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_RD_AHD = 5'b00010,
      S_MODIFY = 5'b00100,
      S_WR_CUR = 5'b01000,
      S_HOLD   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   cell_entry_type     cur_ff, cur_in_entry;
   cell_entry_type     cur_new_ff;
   upd_ctl_type        ctl_ff;
   logic [CELLS_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_ahead_ff;
   logic signed [1:0]  rsp_wall_ff;
   logic [1:0]         rsp_cell_ff;
   logic [CELLS_W-1:0] rsp_left_ff;

   logic [4:0]         cur_x, cur_y, ahead_x, ahead_y;
   logic               cur_in, ahead_in;
   logic [ADDR_W-1:0]  cur_addr, ahead_addr, port_addr;
   logic               req_fire, out_free, out_load;

   logic               tbl_wr_en;
   logic [ADDR_W-1:0]  tbl_wr_addr, tbl_rd_addr;
   cell_entry_type     tbl_wr_data, tbl_rd_data;
   logic               tbl_rd_valid;

   cell_entry_type     ahead_entry, upd_cur, upd_ahead;
   upd_ctl_type        upd_ctl;
   logic [CELLS_W-1:0] upd_count;

   // Handshakes.
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign csr_ready = !reset;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = ((state_ff == S_WR_CUR) || (state_ff == S_HOLD)) && out_free;

   // Coordinates of the current cell and the cell ahead; a step west of column
   // zero or north of row zero wraps high and so falls outside the grid.
   always_comb begin
      cur_x   = {2'b0, req_ff.cell_x};
      cur_y   = {2'b0, req_ff.cell_y};
      ahead_x = cur_x;
      ahead_y = cur_y;
      case (req_ff.heading)
         DIR_SOUTH: ahead_y = cur_y + 5'd1;
         DIR_WEST:  ahead_x = cur_x - 5'd1;
         DIR_NORTH: ahead_y = cur_y - 5'd1;
         DIR_EAST:  ahead_x = cur_x + 5'd1;
         default:   ahead_x = cur_x;
      endcase
      cur_in     = (cur_x < 5'(GRID_WIDTH)) && (cur_y < 5'(GRID_HEIGHT));
      ahead_in   = (ahead_x < 5'(GRID_WIDTH)) && (ahead_y < 5'(GRID_HEIGHT));
      cur_addr   = ADDR_W'(int'(cur_y[3:0]) * GRID_WIDTH + int'(cur_x[3:0]));
      ahead_addr = ADDR_W'(int'(ahead_y[3:0]) * GRID_WIDTH + int'(ahead_x[3:0]));
      port_addr  = ADDR_W'(int'(req_cell_y) * GRID_WIDTH + int'(req_cell_x));
   end

   // Memory port use: the current cell is read as the request is taken, the cell
   // ahead next; the ahead entry is written back first, then the current one.
   always_comb begin
      tbl_rd_addr = (state_ff == S_IDLE) ? port_addr : ahead_addr;
      tbl_wr_en   = ((state_ff == S_MODIFY) && upd_ctl.wr_ahead) ||
                    ((state_ff == S_WR_CUR) && ctl_ff.wr_cur);
      tbl_wr_addr = (state_ff == S_MODIFY) ? ahead_addr : cur_addr;
      tbl_wr_data = (state_ff == S_MODIFY) ? upd_ahead : cur_new_ff;
   end

   mwm_table #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_mwm_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_data  (tbl_wr_data),
      .rd_addr  (tbl_rd_addr),
      .rd_data  (tbl_rd_data),
      .rd_valid (tbl_rd_valid)
   );

   // Unwritten entries read as their reset value.
   assign cur_in_entry = tbl_rd_valid ? tbl_rd_data
                       : reset_entry(cur_x[3:0], cur_y[3:0], GRID_WIDTH, GRID_HEIGHT);
   assign ahead_entry  = tbl_rd_valid ? tbl_rd_data
                       : reset_entry(ahead_x[3:0], ahead_y[3:0], GRID_WIDTH, GRID_HEIGHT);

   mwm_update u_mwm_update (
      .req         (req_ff),
      .cur_in      (cur_in),
      .ahead_in    (ahead_in),
      .cur_entry   (cur_ff),
      .ahead_entry (ahead_entry),
      .count_cur   (count_ff),
      .cur_new     (upd_cur),
      .ahead_new   (upd_ahead),
      .ctl         (upd_ctl),
      .count_new   (upd_count)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_RD_AHD;
         S_RD_AHD: state_in = S_MODIFY;
         S_MODIFY: state_in = S_WR_CUR;
         S_WR_CUR: state_in = out_free ? S_IDLE : S_HOLD;
         S_HOLD:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Cells-left count: a configuration write reloads it, with priority over the update in S_MODIFY.
   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_initial_cells;
      end else if (state_ff == S_MODIFY) begin
         count_in = upd_count;
      end
   end

   // Response register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_in = '{operation:   req_operation,
                     cell_x:      req_cell_x,
                     cell_y:      req_cell_y,
                     heading:     req_heading,
                     wall_closed: req_wall_closed,
                     turns:       req_turns};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CELLS_RESET;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_MODIFY) begin
            ctl_ff <= upd_ctl;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_in;
      end
      if (state_ff == S_RD_AHD) begin
         cur_ff <= cur_in_entry;
      end
      if (state_ff == S_MODIFY) begin
         cur_new_ff <= upd_cur;
      end
      if (out_load) begin
         rsp_ahead_ff <= ctl_ff.ahead_status;
         rsp_wall_ff  <= $signed(ctl_ff.asked_wall);
         rsp_cell_ff  <= ctl_ff.cell_status;
         rsp_left_ff  <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ahead_status = rsp_ahead_ff;
   assign rsp_asked_wall   = rsp_wall_ff;
   assign rsp_cell_status  = rsp_cell_ff;
   assign rsp_cells_left   = rsp_left_ff;

endmodule

// ===== rtl/core/mwm_checker.sv =====
// ----------------------------------------------------------------------------
// Wall map store port checker
// Watches the top-level ports for response holding and request sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_ahead_status,
   input logic signed [1:0] rsp_asked_wall,
   input logic [1:0]        rsp_cell_status,
   input logic [8:0]        rsp_cells_left
);

   // A stalled response keeps its valid and its fields.
   `MWM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ahead_status) && $stable(rsp_asked_wall) && $stable(rsp_cell_status) && $stable(rsp_cells_left), "response changed while stalled")

   // Only one transaction is at work: ready stays low while the memory is in use.
   `MWM_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready, "request taken while another is in progress")

   // A fresh response appears only after a request transaction.
   `MWM_ASSERT(a_rsp_latency, $rose(rsp_valid) |-> $past(req_valid && req_ready, 4), "response without matching request")

endmodule

bind maze_wall_map_store mwm_checker u_mwm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_ahead_status (rsp_ahead_status),
   .rsp_asked_wall   (rsp_asked_wall),
   .rsp_cell_status  (rsp_cell_status),
   .rsp_cells_left   (rsp_cells_left)
);
